### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sha1_pkg.sv
`default_nettype none

package sha1_pkg;

  localparam int unsigned NUM_WORDS = 5;

  localparam logic [31:0] SHA1_IV [NUM_WORDS] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [31:0] K_R0 = 32'h5a827999;
  localparam logic [31:0] K_R1 = 32'h6ed9eba1;
  localparam logic [31:0] K_R2 = 32'h8f1bbcdc;
  localparam logic [31:0] K_R3 = 32'hca62c1d6;

  localparam logic [6:0] RND_END0 = 7'd19;
  localparam logic [6:0] RND_END1 = 7'd39;
  localparam logic [6:0] RND_END2 = 7'd59;
  localparam logic [6:0] RND_LAST = 7'd79;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_FILL  = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [2:0] IDX_LAST  = 3'd4;

  typedef enum logic [1:0] {
    SEL_MSG,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD80,
    S_PADZ,
    S_PADLEN,
    S_DRAIN
  } ctrl_state_t;

  typedef struct packed {
    logic      put;
    byte_sel_t sel;
    logic      count_inc;
    logic      latch_len;
    logic      load_block;
    logic      finish;
  } cmd_t;

  typedef struct packed {
    logic       pending;
    logic [5:0] fill;
    logic       core_busy;
    logic       out_busy;
  } sts_t;

endpackage

`default_nettype wire

### rtl/sha1_ctrl.sv
`default_nettype none

module sha1_ctrl
  import sha1_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic func,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !sts.pending && func) state_next = S_PAD80;
      end
      S_PAD80: begin
        if (!sts.pending) state_next = S_PADZ;
      end
      S_PADZ: begin
        if (!sts.pending && sts.fill == LEN_FILL) state_next = S_PADLEN;
      end
      S_PADLEN: begin
        if (!sts.pending && sts.fill == FILL_LAST) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.pending && !sts.core_busy && !sts.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.sel        = SEL_MSG;
    cmd.load_block = sts.pending && !sts.core_busy;
    in_stall       = (state != S_IDLE) || sts.pending;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !sts.pending) begin
          if (!func) begin
            cmd.put       = 1'b1;
            cmd.count_inc = 1'b1;
          end else begin
            cmd.latch_len = 1'b1;
          end
        end
      end
      S_PAD80: begin
        cmd.put = !sts.pending;
        cmd.sel = SEL_PAD;
      end
      S_PADZ: begin
        cmd.put = !sts.pending && (sts.fill != LEN_FILL);
        cmd.sel = SEL_ZERO;
      end
      S_PADLEN: begin
        cmd.put = !sts.pending;
        cmd.sel = SEL_LEN;
      end
      S_DRAIN: begin
        cmd.finish = !sts.pending && !sts.core_busy && !sts.out_busy;
      end
      default: begin
        cmd.put = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/sha1_dp.sv
`default_nettype none

module sha1_dp
  import sha1_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  data_byte,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic        out_stall,
  output logic             out_valid,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  // byte gathering
  logic [511:0] blk;
  logic [5:0]   fill;
  logic         pending;
  logic [63:0]  count;
  logic [63:0]  len_sh;
  logic [7:0]   put_byte;

  // round engine
  logic [31:0] w [16];
  logic [31:0] vars [NUM_WORDS];
  logic [31:0] chain [NUM_WORDS];
  logic [6:0]  rnd;
  logic        busy;
  logic        fin;

  logic [31:0] a, b, c, d, e;
  logic [31:0] f, k, w_new, tmp;

  // result stage
  logic [159:0] dig;
  logic [2:0]   out_cnt;

  always_comb begin
    case (cmd.sel)
      SEL_MSG:  put_byte = data_byte;
      SEL_PAD:  put_byte = PAD_BYTE;
      SEL_ZERO: put_byte = 8'h00;
      SEL_LEN:  put_byte = len_sh[63:56];
      default:  put_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.put) blk <= {blk[503:0], put_byte};
    if (cmd.latch_len) begin
      len_sh <= {count[60:0], 3'b000};
    end else if (cmd.put && cmd.sel == SEL_LEN) begin
      len_sh <= {len_sh[55:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      pending <= 1'b0;
      count   <= '0;
    end else begin
      if (cmd.put) begin
        fill <= fill + 6'd1;
      end
      if (cmd.put && fill == FILL_LAST) begin
        pending <= 1'b1;
      end else if (cmd.load_block) begin
        pending <= 1'b0;
      end
      if (cmd.latch_len) begin
        count <= '0;
      end else if (cmd.count_inc) begin
        count <= count + 64'd1;
      end
    end
  end

  assign a = vars[0];
  assign b = vars[1];
  assign c = vars[2];
  assign d = vars[3];
  assign e = vars[4];

  always_comb begin
    if (rnd <= RND_END0) begin
      f = (b & c) | (d & ~b);
      k = K_R0;
    end else if (rnd <= RND_END1) begin
      f = b ^ c ^ d;
      k = K_R1;
    end else if (rnd <= RND_END2) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_R2;
    end else begin
      f = b ^ c ^ d;
      k = K_R3;
    end
  end

  assign w_new = w[13] ^ w[8] ^ w[2] ^ w[0];
  assign tmp   = {a[26:0], a[31:27]} + f + e + w[0] + k;

  always_ff @(posedge clk) begin
    if (cmd.load_block) begin
      for (int i = 0; i < 16; i++) begin
        w[i] <= blk[511 - 32*i -: 32];
      end
      for (int i = 0; i < NUM_WORDS; i++) begin
        vars[i] <= chain[i];
      end
    end else if (busy) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15]   <= {w_new[30:0], w_new[31]};
      vars[0] <= tmp;
      vars[1] <= a;
      vars[2] <= {b[1:0], b[31:2]};
      vars[3] <= c;
      vars[4] <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      rnd  <= '0;
    end else begin
      if (cmd.load_block) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 7'd1;
        if (rnd == RND_LAST) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
      if (fin) fin <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        chain[i] <= SHA1_IV[i];
      end
    end else if (fin) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        chain[i] <= chain[i] + vars[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      dig <= {chain[0], chain[1], chain[2], chain[3], chain[4]};
    end else if (out_valid && !out_stall) begin
      dig <= {dig[127:0], 32'h0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_cnt   <= '0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
      out_cnt   <= '0;
    end else if (out_valid && !out_stall) begin
      if (out_cnt == IDX_LAST) begin
        out_valid <= 1'b0;
      end else begin
        out_cnt <= out_cnt + 3'd1;
      end
    end
  end

  assign digest_word = dig[159:128];
  assign word_index  = out_cnt;
  assign last_word   = (out_cnt == IDX_LAST);

  assign sts.pending   = pending;
  assign sts.fill      = fill;
  assign sts.core_busy = busy || fin;
  assign sts.out_busy  = out_valid;

endmodule

`default_nettype wire

### rtl/sha1_byte_stream_hasher_unit.sv
// channel | direction | handshake           | fields
// in      | to unit   | in_valid / in_stall   | func, data_byte
// out     | from unit | out_valid / out_stall | digest_word, word_index, last_word
//
// A full 64-byte block is copied into the round engine and compressed in
// 80 rounds plus a chain update; the next block's bytes are taken
// meanwhile. Input stalls while a full block waits for the engine and
// during a finish. A finish walks padding one byte a cycle while no full
// block waits (one or two blocks), then gives five words. Reset clears
// control and chain; no clearing pass.
`default_nettype none

`include "assert_macros.svh"

module sha1_byte_stream_hasher_unit
  import sha1_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        func,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  cmd_t cmd;
  sts_t sts;

  sha1_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sha1_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .cmd         (cmd),
    .sts         (sts),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  `ASSERT_IMPLY(a_no_put_full, clk, rst, cmd.put, !sts.pending, "byte put into full block")
  `ASSERT_IMPLY(a_load_idle, clk, rst, cmd.load_block, !sts.core_busy, "block load while busy")
  `ASSERT_IMPLY(a_finish_idle, clk, rst, cmd.finish, !out_valid && !sts.core_busy, "early finish")
  `ASSERT_NEXT(a_last_drops, clk, rst, out_valid && !out_stall && last_word, !out_valid, "extra item")

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb
  import sha1_pkg::*;
;

  localparam logic FUNC_ABSORB = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned ITEM_TARGET = 180;

  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_word_t;

  class digest_tracker;
    logic [31:0]  chain [NUM_WORDS];
    logic [7:0]   block_bytes [64];
    logic [5:0]   fill;
    logic [63:0]  byte_count;
    digest_word_t expected_words [$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      foreach (chain[i]) chain[i] = SHA1_IV[i];
      fill = '0;
      byte_count = '0;
    endfunction

    function void compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, x, tmp;
      int r;
      for (r = 0; r < 16; r++)
        w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (r = 0; r < 80; r++) begin
        if (r >= 16) begin
          x = w[(r-3) & 15] ^ w[(r-8) & 15] ^ w[(r-14) & 15] ^ w[r & 15];
          w[r & 15] = {x[30:0], x[31]};
        end
        if (r <= int'(RND_END0)) begin
          f = (b & c) | (d & ~b);
          k = K_R0;
        end else if (r <= int'(RND_END1)) begin
          f = b ^ c ^ d;
          k = K_R1;
        end else if (r <= int'(RND_END2)) begin
          f = (b & c) | (b & d) | (c & d);
          k = K_R2;
        end else begin
          f = b ^ c ^ d;
          k = K_R3;
        end
        tmp = {a[26:0], a[31:27]} + f + e + w[r & 15] + k;
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = tmp;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endfunction

    function void put_byte(input logic [7:0] v);
      block_bytes[fill] = v;
      fill = fill + 6'd1;
      if (fill == 6'd0) compress();
    endfunction

    function void note_item(input logic f, input logic [7:0] b);
      logic [63:0] bit_len;
      digest_word_t dw;
      if (f == FUNC_ABSORB) begin
        byte_count = byte_count + 64'd1;
        put_byte(b);
      end else begin
        bit_len = byte_count << 3;
        put_byte(PAD_BYTE);
        while (fill != LEN_FILL) put_byte(8'h00);
        for (int i = 7; i >= 0; i--) put_byte(bit_len[8*i +: 8]);
        for (int i = 0; i < NUM_WORDS; i++) begin
          dw.digest_word = chain[i];
          dw.word_index = 3'(i);
          dw.last_word = (3'(i) == IDX_LAST);
          expected_words.push_back(dw);
        end
        restart();
      end
    endfunction

    function void check_word(input logic [31:0] dword, input logic [2:0] idx, input logic lw);
      digest_word_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected digest word %h (index %0d)", dword, idx);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      if (dword !== want.digest_word) begin
        $error("digest_word: expected %h, got %h", want.digest_word, dword);
        mismatches++;
      end
      if (idx !== want.word_index) begin
        $error("word_index: expected %0d, got %0d", want.word_index, idx);
        mismatches++;
      end
      if (lw !== want.last_word) begin
        $error("last_word: expected %b, got %b", want.last_word, lw);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = FUNC_ABSORB;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  int unsigned items_sent = 0;
  int unsigned send_idle_pct = 31;
  int unsigned recv_stall_pct = 52;
  int unsigned cycle_cnt = 0;

  digest_tracker tracker = new();

  sha1_byte_stream_hasher_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.check_word(digest_word, word_index, last_word);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_item(input logic f, input logic [7:0] b);
    if (items_sent < 60) begin
      send_idle_pct = 31;
      recv_stall_pct = 52;
    end else if (items_sent < 120) begin
      send_idle_pct = 52;
      recv_stall_pct = 31;
    end else begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      func <= 1'($urandom_range(1));
      data_byte <= 8'($urandom_range(255));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    data_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    tracker.note_item(f, b);
    items_sent++;
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_item(FUNC_ABSORB, 8'($urandom_range(255)));
    send_item(FUNC_FINISH, 8'($urandom_range(255)));
  endtask

  initial begin
    int unsigned boundary_lens [8];
    int unsigned pick;
    int unsigned len;

    boundary_lens = '{55, 56, 57, 63, 64, 65, 119, 120};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty message, ignored byte on finish
    send_item(FUNC_FINISH, 8'hff);
    send_item(FUNC_ABSORB, 8'h00);
    send_item(FUNC_ABSORB, 8'hff);
    send_item(FUNC_ABSORB, 8'h80);
    send_item(FUNC_ABSORB, 8'h7f);
    send_item(FUNC_FINISH, 8'h00);
    send_item(FUNC_ABSORB, 8'h61);
    send_item(FUNC_ABSORB, 8'h62);
    send_item(FUNC_ABSORB, 8'h63);
    send_item(FUNC_FINISH, 8'h5a);
    send_item(FUNC_FINISH, 8'ha5);

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(9);
      if (pick < 7) len = $urandom_range(8);
      else if (pick < 9) len = boundary_lens[$urandom_range(7)];
      else len = $urandom_range(130);
      // keep the total near the target, the finish item included
      if (len > ITEM_TARGET - 1 - items_sent) len = ITEM_TARGET - 1 - items_sent;
      send_message(len);
    end
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
